>>> rtl/assert_macros.svh
// Assertion macros of the packetizer RTL, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define PSRTP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PSRTP_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/psrtp_pkg.sv
// Shared types, constants and header byte functions of the PS over RTP packetizer.
`default_nettype none

package psrtp_pkg;

    localparam int LEN_MAX_W   = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [4:0] VID_HDR_LAST = 5'd27;
    localparam logic [4:0] AUD_HDR_LAST = 5'd20;
    localparam logic [4:0] VID_HDR_LEN  = 5'd28;
    localparam logic [4:0] AUD_HDR_LEN  = 5'd21;
    localparam logic [3:0] RTP_HDR_LAST = 4'd11;

    localparam logic [31:0] PACK_RATE = 32'd19460;
    localparam logic [7:0]  SID_VIDEO = 8'he0;
    localparam logic [7:0]  SID_AUDIO = 8'hc0;

    localparam logic [1:0] CFG_SSRC    = 2'd0;
    localparam logic [1:0] CFG_TS_STEP = 2'd1;
    localparam logic [1:0] CFG_SR_IDX  = 2'd2;
    localparam logic [1:0] CFG_CH_CFG  = 2'd3;

    typedef struct packed {
        logic [7:0]           data;
        logic                 start;
        logic                 audio;
        logic [LEN_MAX_W-1:0] len;
    } t_entry;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_RTP,
        BS_PSH
    } t_bstate;

    // PES header byte i (0..13)
    function automatic logic [7:0] pes_byte(input logic [3:0] i, input logic [7:0] sid,
                                            input logic [15:0] plen, input logic [31:0] t);
        logic [31:0] v;
        v = 32'h0;
        unique case (i)
            4'd0, 4'd1: v = 32'h00;
            4'd2:       v = 32'h01;
            4'd3:       v = {24'h0, sid};
            4'd4:       v = {24'h0, plen[15:8]};
            4'd5:       v = {24'h0, plen[7:0]};
            4'd6:       v = 32'h8c;
            4'd7:       v = 32'h80;
            4'd8:       v = 32'h05;
            4'd9:       v = 32'h21 | (((t >> 30) & 32'h7) << 1);
            4'd10:      v = (t >> 22) & 32'hff;
            4'd11:      v = (((t >> 15) & 32'h7f) << 1) | 32'h1;
            4'd12:      v = (t >> 7) & 32'hff;
            4'd13:      v = ((t & 32'h7f) << 1) | 32'h1;
            default:    v = 32'h0;
        endcase
        return v[7:0];
    endfunction

    // Program stream header byte idx of a video (pack + PES) or audio (PES + ADTS) frame
    function automatic logic [7:0] hdr_byte(input logic [4:0] idx, input logic audio,
                                            input logic [31:0] t, input logic [15:0] plen,
                                            input logic [12:0] fl, input logic [3:0] sr,
                                            input logic [2:0] ch);
        logic [31:0] v;
        v = 32'h0;
        if (!audio) begin
            if (idx >= 5'd14) begin
                v = {24'h0, pes_byte(4'(idx - 5'd14), SID_VIDEO, plen, t)};
            end else begin
                unique case (idx[3:0])
                    4'd0, 4'd1: v = 32'h00;
                    4'd2:       v = 32'h01;
                    4'd3:       v = 32'hba;
                    4'd4:       v = 32'h44 | (((t >> 30) & 32'h7) << 3) | ((t >> 28) & 32'h3);
                    4'd5:       v = (t >> 20) & 32'hff;
                    4'd6:       v = 32'h04 | (((t >> 15) & 32'h1f) << 3) | ((t >> 13) & 32'h3);
                    4'd7:       v = (t >> 5) & 32'hff;
                    4'd8:       v = 32'h04 | ((t & 32'h1f) << 3);
                    4'd9:       v = 32'h01;
                    4'd10:      v = (PACK_RATE >> 14) & 32'hff;
                    4'd11:      v = (PACK_RATE >> 6) & 32'hff;
                    4'd12:      v = 32'h03 | ((PACK_RATE & 32'h3f) << 2);
                    4'd13:      v = 32'hf8;
                    default:    v = 32'h0;
                endcase
            end
        end else begin
            if (idx < 5'd14) begin
                v = {24'h0, pes_byte(idx[3:0], SID_AUDIO, plen, t)};
            end else begin
                unique case (idx)
                    5'd14:   v = 32'hff;
                    5'd15:   v = 32'hf9;
                    5'd16:   v = {24'h0, 2'b01, sr, 1'b0, ch[2]};
                    5'd17:   v = {24'h0, ch[1:0], 4'h0, fl[12:11]};
                    5'd18:   v = {24'h0, fl[10:3]};
                    5'd19:   v = {24'h0, fl[2:0], 5'h1f};
                    5'd20:   v = 32'hfc;
                    default: v = 32'h0;
                endcase
            end
        end
        return v[7:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/psrtp_front.sv
// Front end: accepts input bytes, drops stray ones, queues frame starts and payload bytes.
`default_nettype none

module psrtp_front #(
    parameter int FRAME_LEN_BITS = 20
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_frame_is_audio,
    input  wire logic [19:0]           i_frame_length,
    input  wire logic                  i_frame_start,
    input  wire logic                  i_q_ready,
    output logic                       o_q_push,
    output psrtp_pkg::t_entry          o_q_entry
);

    localparam logic [psrtp_pkg::LEN_MAX_W-1:0] LEN_MASK =
        (psrtp_pkg::LEN_MAX_W'(1) << FRAME_LEN_BITS) - psrtp_pkg::LEN_MAX_W'(1);

    logic [psrtp_pkg::LEN_MAX_W-1:0] r_rem, n_rem;
    logic [psrtp_pkg::LEN_MAX_W-1:0] len_m;
    logic                            accept;

    assign len_m      = psrtp_pkg::LEN_MAX_W'(i_frame_length) & LEN_MASK;
    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;

    assign o_q_entry.data  = i_data_byte;
    assign o_q_entry.start = i_frame_start;
    assign o_q_entry.audio = i_frame_is_audio;
    assign o_q_entry.len   = len_m;

    always_comb begin
        n_rem    = r_rem;
        o_q_push = 1'b0;
        if (accept) begin
            if (i_frame_start) begin
                // zero length abandons the frame and drops the byte
                n_rem    = (len_m == '0) ? '0 : len_m - 1'b1;
                o_q_push = (len_m != '0);
            end else if (r_rem != '0) begin
                n_rem    = r_rem - 1'b1;
                o_q_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

endmodule

`default_nettype wire

>>> rtl/psrtp_queue.sv
// Short request queue between the front and back ends.
`default_nettype none

module psrtp_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire psrtp_pkg::t_entry i_entry,
    output logic                   o_ready,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output psrtp_pkg::t_entry      o_head
);

    psrtp_pkg::t_entry r_mem [psrtp_pkg::QUEUE_DEPTH];
    logic [psrtp_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [psrtp_pkg::QPTR_W:0]   r_cnt;
    logic                         do_pop;

    assign o_ready = (r_cnt != (psrtp_pkg::QPTR_W+1)'(psrtp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (psrtp_pkg::QPTR_W+1)'(i_push)
                           - (psrtp_pkg::QPTR_W+1)'(do_pop);
        end
    end

endmodule

`default_nettype wire

>>> rtl/psrtp_back.sv
// Back end: emits RTP headers, program stream headers and payload bytes into the output register.
`default_nettype none

module psrtp_back #(
    parameter int RTP_PAYLOAD_MAX = 1400,
    parameter int FRAME_LEN_BITS  = 20
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire psrtp_pkg::t_entry i_q_head,
    output logic                   o_q_pop,
    input  wire logic [31:0]       i_ssrc,
    input  wire logic [31:0]       i_ts_step,
    input  wire logic [3:0]        i_sr_idx,
    input  wire logic [2:0]        i_ch_cfg,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_packet_start,
    output logic                   o_packet_end,
    output logic                   o_run_last
);

    localparam int FILL_W = $clog2(RTP_PAYLOAD_MAX + 1);
    localparam int SBL_W  = FRAME_LEN_BITS + 1;

    psrtp_pkg::t_bstate r_state, n_state;
    logic              r_ret_psh, n_ret_psh;
    logic              r_rtp_done, n_rtp_done;
    logic              r_head_done, n_head_done;
    logic [4:0]        r_idx, n_idx;
    logic [3:0]        r_rtp_idx, n_rtp_idx;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [SBL_W-1:0]  r_sbl, n_sbl;
    logic              r_kind, n_kind;
    logic [15:0]       r_plen, n_plen;
    logic [12:0]       r_fl, n_fl;
    logic [31:0]       r_ts, n_ts;
    logic [15:0]       r_seq, n_seq;
    logic              r_ovalid, n_ovalid;
    logic [7:0]        r_obyte, n_obyte;
    logic              r_ops, n_ops, r_ope, n_ope, r_olast, n_olast;

    logic              adv;
    logic [SBL_W-1:0]  ps_sbl;
    logic [FILL_W-1:0] ps_fill;
    logic              ps_end;
    logic              ps_take;

    function automatic logic [7:0] rtp_byte(input logic [3:0] i, input logic [15:0] seq,
                                            input logic [31:0] t, input logic [31:0] ssrc);
        logic [7:0] v;
        v = 8'h0;
        unique case (i)
            4'd0:    v = 8'h80;
            4'd1:    v = 8'h60;
            4'd2:    v = seq[15:8];
            4'd3:    v = seq[7:0];
            4'd4:    v = t[31:24];
            4'd5:    v = t[23:16];
            4'd6:    v = t[15:8];
            4'd7:    v = t[7:0];
            4'd8:    v = ssrc[31:24];
            4'd9:    v = ssrc[23:16];
            4'd10:   v = ssrc[15:8];
            4'd11:   v = ssrc[7:0];
            default: v = 8'h0;
        endcase
        return v;
    endfunction

    assign adv     = !r_ovalid || i_out_ready;
    assign ps_sbl  = (r_sbl != '0) ? r_sbl - 1'b1 : r_sbl;
    assign ps_fill = r_fill + 1'b1;
    assign ps_end  = (ps_fill >= FILL_W'(RTP_PAYLOAD_MAX)) || (ps_sbl == '0);

    always_comb begin
        n_state     = r_state;
        n_ret_psh   = r_ret_psh;
        n_rtp_done  = r_rtp_done;
        n_head_done = r_head_done;
        n_idx       = r_idx;
        n_rtp_idx   = r_rtp_idx;
        n_fill      = r_fill;
        n_sbl       = r_sbl;
        n_kind      = r_kind;
        n_plen      = r_plen;
        n_fl        = r_fl;
        n_ts        = r_ts;
        n_seq       = r_seq;
        n_ovalid    = r_ovalid && !i_out_ready;
        n_obyte     = r_obyte;
        n_ops       = r_ops;
        n_ope       = r_ope;
        n_olast     = r_olast;
        o_q_pop     = 1'b0;
        ps_take     = 1'b0;

        unique case (r_state)
            psrtp_pkg::BS_IDLE: begin
                if (i_q_valid && adv) begin
                    if (i_q_head.start && !r_head_done) begin
                        // new frame: latch kind and lengths, open a fresh packet
                        n_kind      = i_q_head.audio;
                        n_plen      = i_q_head.audio ? 16'(i_q_head.len + 16'd15)
                                                     : 16'(i_q_head.len + 16'd8);
                        n_fl        = 13'(i_q_head.len + 13'd7);
                        n_sbl       = SBL_W'(i_q_head.audio ? psrtp_pkg::AUD_HDR_LEN
                                                            : psrtp_pkg::VID_HDR_LEN)
                                    + SBL_W'(i_q_head.len);
                        n_fill      = '0;
                        n_idx       = '0;
                        n_rtp_done  = 1'b0;
                        n_head_done = 1'b1;
                        n_state     = psrtp_pkg::BS_PSH;
                    end else if (r_fill == '0 && !r_rtp_done) begin
                        n_rtp_idx = '0;
                        n_ret_psh = 1'b0;
                        n_state   = psrtp_pkg::BS_RTP;
                    end else begin
                        ps_take     = 1'b1;
                        n_obyte     = i_q_head.data;
                        n_olast     = 1'b1;
                        o_q_pop     = 1'b1;
                        n_head_done = 1'b0;
                    end
                end
            end
            psrtp_pkg::BS_PSH: begin
                if (adv) begin
                    if (r_fill == '0 && !r_rtp_done) begin
                        n_rtp_idx = '0;
                        n_ret_psh = 1'b1;
                        n_state   = psrtp_pkg::BS_RTP;
                    end else begin
                        ps_take = 1'b1;
                        n_obyte = psrtp_pkg::hdr_byte(r_idx, r_kind, r_ts, r_plen, r_fl,
                                                      i_sr_idx, i_ch_cfg);
                        n_olast = 1'b0;
                        n_idx   = r_idx + 1'b1;
                        if (r_idx == (r_kind ? psrtp_pkg::AUD_HDR_LAST
                                             : psrtp_pkg::VID_HDR_LAST)) begin
                            n_state = psrtp_pkg::BS_IDLE;
                        end
                    end
                end
            end
            psrtp_pkg::BS_RTP: begin
                if (adv) begin
                    n_ovalid  = 1'b1;
                    n_obyte   = rtp_byte(r_rtp_idx, r_seq, r_ts, i_ssrc);
                    n_ops     = (r_rtp_idx == '0);
                    n_ope     = 1'b0;
                    n_olast   = 1'b0;
                    n_rtp_idx = r_rtp_idx + 1'b1;
                    if (r_rtp_idx == psrtp_pkg::RTP_HDR_LAST) begin
                        n_seq      = r_seq + 1'b1;
                        n_rtp_done = 1'b1;
                        n_state    = r_ret_psh ? psrtp_pkg::BS_PSH : psrtp_pkg::BS_IDLE;
                    end
                end
            end
            default: n_state = psrtp_pkg::BS_IDLE;
        endcase

        // one program stream byte leaves: count it against packet and frame
        if (ps_take) begin
            n_ovalid   = 1'b1;
            n_ops      = 1'b0;
            n_ope      = ps_end;
            n_rtp_done = 1'b0;
            n_sbl      = ps_sbl;
            n_fill     = ps_end ? '0 : ps_fill;
            if (ps_sbl == '0 && !r_kind) begin
                n_ts = r_ts + i_ts_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psrtp_pkg::BS_IDLE;
            r_ret_psh   <= 1'b0;
            r_rtp_done  <= 1'b0;
            r_head_done <= 1'b0;
            r_idx       <= '0;
            r_rtp_idx   <= '0;
            r_fill      <= '0;
            r_sbl       <= '0;
            r_kind      <= 1'b0;
            r_ts        <= '0;
            r_seq       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret_psh   <= n_ret_psh;
            r_rtp_done  <= n_rtp_done;
            r_head_done <= n_head_done;
            r_idx       <= n_idx;
            r_rtp_idx   <= n_rtp_idx;
            r_fill      <= n_fill;
            r_sbl       <= n_sbl;
            r_kind      <= n_kind;
            r_ts        <= n_ts;
            r_seq       <= n_seq;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plen  <= n_plen;
        r_fl    <= n_fl;
        r_obyte <= n_obyte;
        r_ops   <= n_ops;
        r_ope   <= n_ope;
        r_olast <= n_olast;
    end

    assign o_out_valid    = r_ovalid;
    assign o_out_byte     = r_obyte;
    assign o_packet_start = r_ops;
    assign o_packet_end   = r_ope;
    assign o_run_last     = r_olast;

endmodule

`default_nettype wire

>>> rtl/ps_rtp_frame_packetizer.sv
// Top level of the MPEG-2 program stream over RTP packetizer.
// Input channel: one coded frame byte per request (i_in_valid / o_in_ready), with
// frame_start, frame_is_audio and frame_length on the first byte of each frame.
// Output channel: one RTP stream byte per request (o_out_valid / i_out_ready), flagged
// with packet_start, packet_end and run_last (last byte caused by one input byte).
// Configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_addr
// (0 ssrc, 1 timestamp step, 2 ADTS sample rate index, 3 ADTS channel config).
// Flow: an accepted input byte is written into the request queue, then registered into the
// output register when no header is due. Payload bytes sustain 1 byte per cycle while the
// receiver does not stall; a frame start first emits 12 RTP header bytes, then 28 (video)
// or 21 (audio) PS header bytes, each later packet start 12 header bytes, all emitted one
// per cycle by the back end sequencer while the receiver does not stall.
// A 4-entry request queue sits between the front end and back end, so input keeps
// being accepted while a result waits in the output register; when the receiver stalls
// the output register holds and the queue fills, then o_in_ready drops.
// Reset (synchronous, active low) clears timestamp, sequence number, packet fill and
// the queue, and loads the configuration reset values.
`default_nettype none
`include "assert_macros.svh"

module ps_rtp_frame_packetizer #(
    parameter int RTP_PAYLOAD_MAX = 1400,
    parameter int FRAME_LEN_BITS  = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_frame_is_audio,
    input  wire logic [19:0] i_frame_length,
    input  wire logic        i_frame_start,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_packet_start,
    output logic             o_packet_end,
    output logic             o_run_last
);

    logic [31:0] r_ssrc, r_ts_step;
    logic [3:0]  r_sr_idx;
    logic [2:0]  r_ch_cfg;

    logic              q_push, q_ready, q_valid, q_pop;
    psrtp_pkg::t_entry q_in, q_head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ssrc    <= 32'd0;
            r_ts_step <= 32'd3600;
            r_sr_idx  <= 4'd0;
            r_ch_cfg  <= 3'd0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                psrtp_pkg::CFG_SSRC:    r_ssrc    <= i_cfg_wdata;
                psrtp_pkg::CFG_TS_STEP: r_ts_step <= i_cfg_wdata;
                psrtp_pkg::CFG_SR_IDX:  r_sr_idx  <= i_cfg_wdata[3:0];
                psrtp_pkg::CFG_CH_CFG:  r_ch_cfg  <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    psrtp_front #(
        .FRAME_LEN_BITS (FRAME_LEN_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_frame_is_audio (i_frame_is_audio),
        .i_frame_length   (i_frame_length),
        .i_frame_start    (i_frame_start),
        .i_q_ready        (q_ready),
        .o_q_push         (q_push),
        .o_q_entry        (q_in)
    );

    psrtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    psrtp_back #(
        .RTP_PAYLOAD_MAX (RTP_PAYLOAD_MAX),
        .FRAME_LEN_BITS  (FRAME_LEN_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_head       (q_head),
        .o_q_pop        (q_pop),
        .i_ssrc         (r_ssrc),
        .i_ts_step      (r_ts_step),
        .i_sr_idx       (r_sr_idx),
        .i_ch_cfg       (r_ch_cfg),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_packet_start (o_packet_start),
        .o_packet_end   (o_packet_end),
        .o_run_last     (o_run_last)
    );

    // a packet's first byte is RTP header, never its last, never a payload byte
    `PSRTP_ASSERT(a_start_not_end, i_clk, i_rst_n, o_out_valid && o_packet_start |-> !o_packet_end && !o_run_last, "packet start flagged as end or payload")
    // a packet's first byte carries the RTP version and flags
    `PSRTP_ASSERT(a_start_is_0x80, i_clk, i_rst_n, o_out_valid && o_packet_start |-> o_out_byte == 8'h80, "packet start byte is not RTP version")
    // queue never pops while empty nor pushes while full
    `PSRTP_ASSERT(a_queue_safe, i_clk, i_rst_n, !(q_push && !q_ready) && !(q_pop && !q_valid), "request queue overflow or underflow")

endmodule

`default_nettype wire

>>> sim/ps_rtp_frame_packetizer_tb.sv
// Self-checking testbench of the PS over RTP frame packetizer.
`default_nettype none

module ps_rtp_frame_packetizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD_MAX = 1400;
    localparam int CYCLE_LIMIT = 600000;

    // one expected byte of the RTP stream
    typedef struct packed {
        logic [7:0] data;
        logic       pkt_first;
        logic       pkt_last;
        logic       run_end;
    } t_rtp_byte;

    // directed row: request fields plus result count where obvious (-1: predictor only)
    typedef struct {
        logic [7:0]  data;
        logic        audio;
        logic [19:0] len;
        logic        start;
        int          n_bytes;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_frame_is_audio = 1'b0;
    logic [19:0] i_frame_length = '0;
    logic        i_frame_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_packet_start;
    logic        o_packet_end;
    logic        o_run_last;

    ps_rtp_frame_packetizer dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state and its copy of the registers
    logic [31:0] ssrc_reg, ts_step_reg;
    logic [3:0]  sr_idx_reg;
    logic [2:0]  ch_cfg_reg;
    logic [31:0] rtp_ts;
    logic [15:0] rtp_seq;
    int unsigned pkt_fill;
    int unsigned ps_left;
    logic        cur_audio;

    t_rtp_byte rtp_q[$];
    int        n_errors = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        hold_cycles = 0;
    int        cycle_cnt = 0;

    // Push one program stream byte, opening an RTP packet if needed
    function automatic void push_ps(input logic [7:0] b);
        t_rtp_byte e;
        logic [7:0] hdr [12];
        logic       last;
        if (pkt_fill == 0) begin
            hdr = '{8'h80, 8'h60, rtp_seq[15:8], rtp_seq[7:0],
                    rtp_ts[31:24], rtp_ts[23:16], rtp_ts[15:8], rtp_ts[7:0],
                    ssrc_reg[31:24], ssrc_reg[23:16], ssrc_reg[15:8], ssrc_reg[7:0]};
            foreach (hdr[k]) begin
                e = '{hdr[k], k == 0, 1'b0, 1'b0};
                rtp_q.push_back(e);
            end
            rtp_seq++;
        end
        if (ps_left > 0) ps_left--;
        pkt_fill++;
        last = (pkt_fill >= PAYLOAD_MAX) || (ps_left == 0);
        e = '{b, 1'b0, last, 1'b0};
        rtp_q.push_back(e);
        if (last) pkt_fill = 0;
        if (ps_left == 0 && !cur_audio) rtp_ts += ts_step_reg;
    endfunction

    // Expected RTP bytes of one accepted request; returns how many
    function automatic int predict_request(input logic [7:0] b, input logic audio,
                                           input logic [19:0] len, input logic start);
        logic [7:0]  hdr [$];
        logic [31:0] t;
        logic [15:0] plen;
        logic [12:0] adts_len;
        int          q0;
        q0 = rtp_q.size();
        t  = rtp_ts;
        if (start) begin
            pkt_fill = 0;
            ps_left  = 0;
            if (len == 0) return 0;   // zero length: abandon and drop
            cur_audio = audio;
            if (!audio) begin
                // pack header, SCR from timestamp, fixed mux rate
                hdr.push_back(8'h00); hdr.push_back(8'h00);
                hdr.push_back(8'h01); hdr.push_back(8'hba);
                hdr.push_back({2'b01, 1'b0, t[31:30], 1'b1, t[29:28]});
                hdr.push_back(t[27:20]);
                hdr.push_back({t[19:15], 1'b1, t[14:13]});
                hdr.push_back(t[12:5]);
                hdr.push_back({t[4:0], 3'b100});
                hdr.push_back(8'h01);
                hdr.push_back(psrtp_pkg::PACK_RATE[21:14]);
                hdr.push_back(psrtp_pkg::PACK_RATE[13:6]);
                hdr.push_back({psrtp_pkg::PACK_RATE[5:0], 2'b11});
                hdr.push_back(8'hf8);
                plen = 16'(len + 20'd8);
            end else begin
                plen = 16'(len + 20'd15);
            end
            // PES header with PTS
            hdr.push_back(8'h00); hdr.push_back(8'h00); hdr.push_back(8'h01);
            hdr.push_back(audio ? psrtp_pkg::SID_AUDIO : psrtp_pkg::SID_VIDEO);
            hdr.push_back(plen[15:8]); hdr.push_back(plen[7:0]);
            hdr.push_back(8'h8c); hdr.push_back(8'h80); hdr.push_back(8'h05);
            hdr.push_back({4'h2, 1'b0, t[31:30], 1'b1});
            hdr.push_back(t[29:22]);
            hdr.push_back({t[21:15], 1'b1});
            hdr.push_back(t[14:7]);
            hdr.push_back({t[6:0], 1'b1});
            if (audio) begin
                // ADTS: ID 1, profile 1, fullness 0x7ff
                adts_len = 13'(len + 20'd7);
                hdr.push_back(8'hff); hdr.push_back(8'hf9);
                hdr.push_back({2'b01, sr_idx_reg, 1'b0, ch_cfg_reg[2]});
                hdr.push_back({ch_cfg_reg[1:0], 4'h0, adts_len[12:11]});
                hdr.push_back(adts_len[10:3]);
                hdr.push_back({adts_len[2:0], 5'h1f});
                hdr.push_back(8'hfc);
            end
            ps_left = hdr.size() + len;
            foreach (hdr[k]) push_ps(hdr[k]);
            push_ps(b);
        end else begin
            if (ps_left == 0) return 0;  // stray byte outside a frame
            push_ps(b);
        end
        rtp_q[rtp_q.size() - 1].run_end = 1'b1;
        return rtp_q.size() - q0;
    endfunction

    // Offer one request, idling at random first; returns predicted result count
    task automatic send(input logic [7:0] b, input logic audio, input logic [19:0] len,
                        input logic start, output int n);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_data_byte      <= b;
        i_frame_is_audio <= audio;
        i_frame_length   <= len;
        i_frame_start    <= start;
        do @(posedge i_clk); while (!o_in_ready);
        n = predict_request(b, audio, len, start);
    endtask

    task automatic cfg_write(input logic [1:0] addr, input logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (addr)
            psrtp_pkg::CFG_SSRC:    ssrc_reg    = val;
            psrtp_pkg::CFG_TS_STEP: ts_step_reg = val;
            psrtp_pkg::CFG_SR_IDX:  sr_idx_reg  = val[3:0];
            psrtp_pkg::CFG_CH_CFG:  ch_cfg_reg  = val[2:0];
            default: ;
        endcase
    endtask

    // Wait until every expected byte is out, then let trailing dropped requests settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (rtp_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Random frames: mostly short well-formed ones, some abandoned, some noise
    task automatic random_frames(input int n_frames);
        int          sel, nb, n, k;
        logic        audio;
        logic [19:0] len;
        for (int f = 0; f < n_frames; f++) begin
            sel   = $urandom_range(99);
            audio = 1'($urandom_range(1));
            if (sel < 78) begin
                len = 20'($urandom_range(40, 1));
                nb  = len;
            end else if (sel < 90) begin
                len = 20'($urandom);      // full field width, cut short
                nb  = $urandom_range(6, 1);
                if (len == 0) len = 20'hfffff;
            end else if (sel < 95) begin
                len = '0;
                nb  = 1;
            end else begin
                // stray bytes outside a frame
                repeat ($urandom_range(3, 1))
                    send(8'($urandom), 1'($urandom), 20'($urandom), 1'b0, n);
                continue;
            end
            for (k = 0; k < nb; k++)
                send(8'($urandom), k == 0 ? audio : 1'($urandom),
                     k == 0 ? len : 20'($urandom), k == 0, n);
        end
    endtask

    // Receiver: checks each accepted byte against the oldest expectation
    always @(posedge i_clk) begin
        t_rtp_byte got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_out_byte, o_packet_start, o_packet_end, o_run_last};
            if (rtp_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected byte %h flags %b%b%b", got.data, got.pkt_first,
                             got.pkt_last, got.run_end);
            end else begin
                want = rtp_q.pop_front();
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: want %h %b%b%b got %h %b%b%b",
                                 want.data, want.pkt_first, want.pkt_last, want.run_end,
                                 got.data, got.pkt_first, got.pkt_last, got.run_end);
                end
            end
        end
        // long hold-off counted here so the queue fills and input stalls
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("ps_rtp_frame_packetizer_tb: FAIL");
            $finish;
        end
    end

    t_row dir_rows [14] = '{
        '{8'h5a, 1'b0, 20'd7,      1'b0, 0},   // stray byte after reset
        '{8'h00, 1'b0, 20'd1,      1'b1, 41},  // one-byte video frame
        '{8'hff, 1'b1, 20'd2,      1'b1, 34},  // audio frame start
        '{8'ha5, 1'b0, 20'd0,      1'b0, 1},   // kind change ignored mid frame
        '{8'h33, 1'b1, 20'd0,      1'b1, 0},   // zero length
        '{8'h11, 1'b0, 20'hfffff,  1'b1, 41},  // longest video frame, abandoned
        '{8'h22, 1'b1, 20'hfffff,  1'b0, 1},
        '{8'h44, 1'b1, 20'd3,      1'b1, 34},  // frame start mid frame
        '{8'h55, 1'b0, 20'd0,      1'b0, 1},
        '{8'h66, 1'b0, 20'd0,      1'b0, 1},
        '{8'h77, 1'b0, 20'd5,      1'b0, 0},   // stray after frame end
        '{8'h80, 1'b1, 20'h80000,  1'b1, 34},  // audio, top length bit
        '{8'h01, 1'b0, 20'd2,      1'b1, 41},
        '{8'hfe, 1'b1, 20'd0,      1'b0, 1}
    };

    initial begin
        int n;
        ssrc_reg = 0; ts_step_reg = 32'd3600; sr_idx_reg = 0; ch_cfg_reg = 0;
        rtp_ts = 0; rtp_seq = 0; pkt_fill = 0; ps_left = 0; cur_audio = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset configuration
        foreach (dir_rows[r]) begin
            send(dir_rows[r].data, dir_rows[r].audio, dir_rows[r].len, dir_rows[r].start, n);
            if (dir_rows[r].n_bytes >= 0 && n != dir_rows[r].n_bytes) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("row %0d: %0d bytes predicted, %0d in table", r, n,
                             dir_rows[r].n_bytes);
            end
        end
        drain();

        // phase: all registers at their maxima, no idling
        cfg_write(psrtp_pkg::CFG_SSRC, 32'hffffffff);
        cfg_write(psrtp_pkg::CFG_TS_STEP, 32'hffffffff);
        cfg_write(psrtp_pkg::CFG_SR_IDX, 32'hf);
        cfg_write(psrtp_pkg::CFG_CH_CFG, 32'h7);
        random_frames(6);
        drain();

        // phase: zero registers, sender idles often
        cfg_write(psrtp_pkg::CFG_SSRC, 32'h0);
        cfg_write(psrtp_pkg::CFG_TS_STEP, 32'h0);
        cfg_write(psrtp_pkg::CFG_SR_IDX, 32'h0);
        cfg_write(psrtp_pkg::CFG_CH_CFG, 32'h0);
        idle_pct = 56;
        random_frames(6);
        idle_pct = 0;
        drain();

        // phase: random registers, receiver stalls often, then a long hold-off
        cfg_write(psrtp_pkg::CFG_SSRC, $urandom);
        cfg_write(psrtp_pkg::CFG_TS_STEP, $urandom);
        cfg_write(psrtp_pkg::CFG_SR_IDX, $urandom);
        cfg_write(psrtp_pkg::CFG_CH_CFG, $urandom);
        stall_pct = 56;
        random_frames(5);
        hold_cycles = 300;
        random_frames(2);
        drain();

        // phase: both sides idle, registers random again
        cfg_write(psrtp_pkg::CFG_SSRC, $urandom);
        cfg_write(psrtp_pkg::CFG_TS_STEP, $urandom);
        cfg_write(psrtp_pkg::CFG_SR_IDX, $urandom);
        cfg_write(psrtp_pkg::CFG_CH_CFG, $urandom);
        idle_pct  = 15;
        stall_pct = 15;
        random_frames(5);
        drain();

        if (rtp_q.size() != 0) n_errors++;
        if (n_errors == 0) begin
            $display("ps_rtp_frame_packetizer_tb: PASS");
        end else begin
            $display("ps_rtp_frame_packetizer_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/psrtp_pkg.sv
rtl/psrtp_front.sv
rtl/psrtp_queue.sv
rtl/psrtp_back.sv
rtl/ps_rtp_frame_packetizer.sv
sim/ps_rtp_frame_packetizer_tb.sv
